>>> hdl/m2x2_pkg.sv
// Shared types and constants for the 2x2 matrix arithmetic unit.
package m2x2_pkg;

  parameter int unsigned ELEM_WIDTH_DEF = 16;
  parameter int unsigned RES_W          = 34;
  parameter int unsigned OP_W           = 3;

  typedef enum logic [OP_W-1:0] {
    OP_MATMUL    = 3'd0,
    OP_MATVEC    = 3'd1,
    OP_TRANSPOSE = 3'd2,
    OP_SCALE     = 3'd3,
    OP_DET       = 3'd4,
    OP_INVERSE   = 3'd5,
    OP_SOLVE     = 3'd6
  } op_e;

endpackage

>>> hdl/matrix2x2_arith_unit.sv
// 2x2 integer matrix arithmetic unit: products, transpose, scale, det, inverse, solve.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one request per transfer: an
//   operation code, matrix M = [a b; c d], matrix O = [p q; r s], vector (x, y)
//   and a scalar. Output channel (out_valid_o / out_ready_i) returns one result
//   per request, in order: res0..res3 and the singular flag.
//   Throughput is one transfer per cycle while the output does not stall; the
//   pipeline depth is set by the bit-serial pipelined divider, one quotient
//   bit per stage, that serves inverse and solve.
//   Every stage carries its own valid bit. A stall on the output holds the
//   whole pipeline in place (in_ready_o drops with it); nothing is lost or
//   repeated. Bubbles in flight move along with the items, they are not
//   squeezed out.
//   Reset clears all valid bits; data registers are not reset.
//   Inverse and solve with a zero determinant give zeros and singular = 1.
//   Quotients truncate toward zero; the determinant used as divisor is kept
//   to at most 64 bits, results are the low 34 bits of the exact value.
module matrix2x2_arith_unit
  import m2x2_pkg::*;
#(
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [OP_W-1:0]              req_type_i,
  input  logic signed [ELEM_WIDTH-1:0] mat_a_i,
  input  logic signed [ELEM_WIDTH-1:0] mat_b_i,
  input  logic signed [ELEM_WIDTH-1:0] mat_c_i,
  input  logic signed [ELEM_WIDTH-1:0] mat_d_i,
  input  logic signed [ELEM_WIDTH-1:0] other_p_i,
  input  logic signed [ELEM_WIDTH-1:0] other_q_i,
  input  logic signed [ELEM_WIDTH-1:0] other_r_i,
  input  logic signed [ELEM_WIDTH-1:0] other_s_i,
  input  logic signed [ELEM_WIDTH-1:0] vec_x_i,
  input  logic signed [ELEM_WIDTH-1:0] vec_y_i,
  input  logic signed [ELEM_WIDTH-1:0] scalar_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [RES_W-1:0]      res0_o,
  output logic signed [RES_W-1:0]      res1_o,
  output logic signed [RES_W-1:0]      res2_o,
  output logic signed [RES_W-1:0]      res3_o,
  output logic                         singular_o
);

  localparam int unsigned W  = ELEM_WIDTH;
  localparam int unsigned PW = 2 * W;                               // product width
  localparam int unsigned DW = (2 * W + 1 > 64) ? 64 : 2 * W + 1;   // det width
  localparam int unsigned QW = W + 1;                               // signed quotient
  localparam int unsigned SW = W + QW;                              // solve product
  localparam int unsigned NL = 4;                                   // divider lanes

  typedef logic signed [W-1:0]     elem_t;
  typedef logic signed [PW-1:0]    prod_t;
  typedef logic signed [RES_W-1:0] res_t;

  typedef struct packed {
    op_e   op;
    elem_t a, b, c, d, x, y;
  } base_t;

  typedef struct packed {
    logic [NL-1:0] neg;
    logic          det_zero;
    logic [DW-1:0] dmag;
    res_t          r0, r1, r2, r3;
    base_t         m;
  } ctl_t;

  typedef struct packed {
    logic [W-1:0] rem;
    logic [W-1:0] num;
    logic [W-1:0] quo;
  } lane_t;

  // Global advance: the output register is empty or being drained.
  logic out_valid_q;
  logic adv;
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // ---------------- Stage A: multipliers ----------------
  op_e   in_op;
  elem_t ml [8];
  elem_t mr [8];
  base_t a_base_d, a_base_q;
  prod_t a_prod_d [8];
  prod_t a_prod_q [8];
  prod_t a_ad_q, a_bc_q;
  logic  a_vld_q;

  assign in_op = op_e'(req_type_i);

  always_comb begin
    ml = '{mat_a_i, mat_b_i, mat_a_i, mat_b_i, mat_c_i, mat_d_i, mat_c_i, mat_d_i};
    case (in_op)
      OP_MATVEC: mr = '{vec_x_i, vec_y_i, vec_x_i, vec_y_i, vec_x_i, vec_y_i, vec_x_i, vec_y_i};
      OP_SCALE:  mr = '{scalar_i, scalar_i, scalar_i, scalar_i,
                        scalar_i, scalar_i, scalar_i, scalar_i};
      default:   mr = '{other_p_i, other_r_i, other_q_i, other_s_i,
                        other_p_i, other_r_i, other_q_i, other_s_i};
    endcase
    for (int i = 0; i < 8; i++) a_prod_d[i] = ml[i] * mr[i];
    a_base_d = '{op: in_op, a: mat_a_i, b: mat_b_i, c: mat_c_i, d: mat_d_i,
                 x: vec_x_i, y: vec_y_i};
  end

  // ---------------- Stage B: sums and determinant ----------------
  logic signed [PW:0] s01, s23, s45, s67, det_full;
  logic signed [DW-1:0] b_det_d, b_det_q;
  res_t  b_r_d [4];
  res_t  b_r_q [4];
  base_t b_base_q;
  logic  b_vld_q;

  always_comb begin
    s01      = a_prod_q[0] + a_prod_q[1];
    s23      = a_prod_q[2] + a_prod_q[3];
    s45      = a_prod_q[4] + a_prod_q[5];
    s67      = a_prod_q[6] + a_prod_q[7];
    det_full = a_ad_q - a_bc_q;
    b_det_d  = DW'(det_full);
    b_r_d    = '{default: '0};
    case (a_base_q.op)
      OP_MATMUL: begin
        b_r_d = '{RES_W'(s01), RES_W'(s23), RES_W'(s45), RES_W'(s67)};
      end
      OP_MATVEC: begin
        b_r_d[0] = RES_W'(s01);
        b_r_d[1] = RES_W'(s45);
      end
      OP_TRANSPOSE: begin
        b_r_d = '{RES_W'(a_base_q.a), RES_W'(a_base_q.c),
                  RES_W'(a_base_q.b), RES_W'(a_base_q.d)};
      end
      OP_SCALE: begin
        b_r_d = '{RES_W'(a_prod_q[0]), RES_W'(a_prod_q[1]),
                  RES_W'(a_prod_q[4]), RES_W'(a_prod_q[5])};
      end
      OP_DET:  b_r_d[0] = RES_W'(b_det_d);
      default: b_r_d = '{default: '0};
    endcase
  end

  // ---------------- Stage C: divider setup ----------------
  logic signed [QW-1:0] num_s [NL];
  ctl_t  c_ctl_d;
  lane_t c_lane_d [NL];

  ctl_t  dv_ctl_q  [W+1];
  lane_t dv_lane_q [W+1][NL];
  logic  dv_vld_q  [W+1];

  always_comb begin
    if (b_base_q.op == OP_INVERSE) begin
      num_s[0] = QW'(b_base_q.d);
      num_s[1] = -(QW'(b_base_q.b));
      num_s[2] = -(QW'(b_base_q.c));
      num_s[3] = QW'(b_base_q.a);
    end else begin
      num_s[0] = QW'(b_base_q.x);
      num_s[1] = QW'(b_base_q.y);
      num_s[2] = '0;
      num_s[3] = '0;
    end
    c_ctl_d.m        = b_base_q;
    c_ctl_d.r0       = b_r_q[0];
    c_ctl_d.r1       = b_r_q[1];
    c_ctl_d.r2       = b_r_q[2];
    c_ctl_d.r3       = b_r_q[3];
    c_ctl_d.det_zero = (b_det_q == '0);
    c_ctl_d.dmag     = b_det_q[DW-1] ? DW'(-b_det_q) : DW'(b_det_q);
    for (int i = 0; i < NL; i++) begin
      c_ctl_d.neg[i]  = num_s[i][QW-1] ^ b_det_q[DW-1];
      c_lane_d[i].rem = '0;
      c_lane_d[i].quo = '0;
      c_lane_d[i].num = num_s[i][QW-1] ? W'(-num_s[i]) : W'(num_s[i]);
    end
  end

  // ---------------- Divider stages: one quotient bit each ----------------
  lane_t dv_lane_d [W+1][NL];

  always_comb begin
    logic [W:0]    trial;
    logic [DW-1:0] trial_x;
    dv_lane_d[0] = c_lane_d;
    for (int k = 1; k <= W; k++) begin
      for (int i = 0; i < NL; i++) begin
        trial   = {dv_lane_q[k-1][i].rem, dv_lane_q[k-1][i].num[W-1]};
        trial_x = DW'(trial);
        dv_lane_d[k][i].num = {dv_lane_q[k-1][i].num[W-2:0], 1'b0};
        if (trial_x >= dv_ctl_q[k-1].dmag) begin
          dv_lane_d[k][i].rem = W'(trial_x - dv_ctl_q[k-1].dmag);
          dv_lane_d[k][i].quo = {dv_lane_q[k-1][i].quo[W-2:0], 1'b1};
        end else begin
          dv_lane_d[k][i].rem = W'(trial);
          dv_lane_d[k][i].quo = {dv_lane_q[k-1][i].quo[W-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------- Stage E: quotient signs ----------------
  logic signed [QW-1:0] e_q_d [NL];
  logic signed [QW-1:0] e_q_q [NL];
  ctl_t e_ctl_q;
  logic e_vld_q;

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      e_q_d[i] = dv_ctl_q[W].neg[i] ? -$signed({1'b0, dv_lane_q[W][i].quo})
                                    :  $signed({1'b0, dv_lane_q[W][i].quo});
    end
  end

  // ---------------- Stage F: solve back-multiply ----------------
  logic signed [SW-1:0] f_dx_d, f_by_d, f_ay_d, f_cx_d;
  logic signed [SW-1:0] f_dx_q, f_by_q, f_ay_q, f_cx_q;
  logic signed [QW-1:0] f_q_q [NL];
  ctl_t f_ctl_q;
  logic f_vld_q;

  assign f_dx_d = e_ctl_q.m.d * e_q_q[0];
  assign f_by_d = e_ctl_q.m.b * e_q_q[1];
  assign f_ay_d = e_ctl_q.m.a * e_q_q[1];
  assign f_cx_d = e_ctl_q.m.c * e_q_q[0];

  // ---------------- Stage G: result select into output register ----------------
  logic signed [SW:0] sol0, sol1;
  res_t o_r_d [4];
  res_t o_r_q [4];
  logic o_sing_d, o_sing_q;

  always_comb begin
    sol0     = f_dx_q - f_by_q;
    sol1     = f_ay_q - f_cx_q;
    o_sing_d = 1'b0;
    o_r_d    = '{f_ctl_q.r0, f_ctl_q.r1, f_ctl_q.r2, f_ctl_q.r3};
    case (f_ctl_q.m.op)
      OP_INVERSE: begin
        o_sing_d = f_ctl_q.det_zero;
        o_r_d    = '{RES_W'(f_q_q[0]), RES_W'(f_q_q[1]),
                     RES_W'(f_q_q[2]), RES_W'(f_q_q[3])};
      end
      OP_SOLVE: begin
        o_sing_d = f_ctl_q.det_zero;
        o_r_d    = '{RES_W'(sol0), RES_W'(sol1), '0, '0};
      end
      default: ;
    endcase
    if (o_sing_d) o_r_d = '{default: '0};
  end

  // ---------------- Registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q     <= 1'b0;
      b_vld_q     <= 1'b0;
      e_vld_q     <= 1'b0;
      f_vld_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k <= W; k++) dv_vld_q[k] <= 1'b0;
    end else if (adv) begin
      a_vld_q     <= in_valid_i;
      b_vld_q     <= a_vld_q;
      dv_vld_q[0] <= b_vld_q;
      for (int k = 1; k <= W; k++) dv_vld_q[k] <= dv_vld_q[k-1];
      e_vld_q     <= dv_vld_q[W];
      f_vld_q     <= e_vld_q;
      out_valid_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_base_q  <= a_base_d;
      a_prod_q  <= a_prod_d;
      a_ad_q    <= mat_a_i * mat_d_i;
      a_bc_q    <= mat_b_i * mat_c_i;
      b_base_q  <= a_base_q;
      b_r_q     <= b_r_d;
      b_det_q   <= b_det_d;
      dv_ctl_q[0] <= c_ctl_d;
      for (int k = 1; k <= W; k++) dv_ctl_q[k] <= dv_ctl_q[k-1];
      for (int k = 0; k <= W; k++) dv_lane_q[k] <= dv_lane_d[k];
      e_ctl_q   <= dv_ctl_q[W];
      e_q_q     <= e_q_d;
      f_ctl_q   <= e_ctl_q;
      f_q_q     <= e_q_q;
      f_dx_q    <= f_dx_d;
      f_by_q    <= f_by_d;
      f_ay_q    <= f_ay_d;
      f_cx_q    <= f_cx_d;
      o_r_q     <= o_r_d;
      o_sing_q  <= o_sing_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res0_o      = o_r_q[0];
  assign res1_o      = o_r_q[1];
  assign res2_o      = o_r_q[2];
  assign res3_o      = o_r_q[3];
  assign singular_o  = o_sing_q;

endmodule

>>> sim/matrix2x2_arith_unit_test.sv
// Self-checking testbench for the 2x2 matrix arithmetic unit.
`timescale 1ns / 1ps

module matrix2x2_arith_unit_test;
  import m2x2_pkg::*;

  localparam int unsigned EW        = ELEM_WIDTH_DEF;
  localparam int unsigned LATENCY   = EW + 5;
  localparam longint      CYCLE_MAX = 400000;
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic signed [EW-1:0] a, b, c, d, p, q, r, s, x, y, k;
  } mat_req_t;

  typedef struct packed {
    logic [RES_W-1:0] r0, r1, r2, r3;
    logic             sing;
  } mat_res_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  mat_req_t cur;
  logic signed [RES_W-1:0] res0_o, res1_o, res2_o, res3_o;
  logic singular_o;

  mat_req_t req_q[$];
  mat_res_t result_q[$];
  bit       failed;
  bit       hold_on;     // stimulus asks receiver for a long hold-off
  longint   cycle_cnt;

  matrix2x2_arith_unit u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .req_type_i(cur.op),
    .mat_a_i(cur.a), .mat_b_i(cur.b), .mat_c_i(cur.c), .mat_d_i(cur.d),
    .other_p_i(cur.p), .other_q_i(cur.q), .other_r_i(cur.r), .other_s_i(cur.s),
    .vec_x_i(cur.x), .vec_y_i(cur.y), .scalar_i(cur.k),
    .out_valid_o, .out_ready_i,
    .res0_o, .res1_o, .res2_o, .res3_o, .singular_o
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Expected result of one request; 64-bit wrap, then low 34 bits.
  function automatic mat_res_t mat_compute(mat_req_t t);
    longint a, b, c, d, p, q, r, s, x, y, k, det, xq, yq;
    longint v0, v1, v2, v3;
    mat_res_t o;
    a = t.a; b = t.b; c = t.c; d = t.d; p = t.p; q = t.q; r = t.r; s = t.s;
    x = t.x; y = t.y; k = t.k;
    det = a * d - b * c;
    v0 = 0; v1 = 0; v2 = 0; v3 = 0; o.sing = 1'b0;
    case (t.op)
      OP_MATMUL: begin
        v0 = a * p + b * r; v1 = a * q + b * s;
        v2 = c * p + d * r; v3 = c * q + d * s;
      end
      OP_MATVEC: begin
        v0 = a * x + b * y; v1 = c * x + d * y;
      end
      OP_TRANSPOSE: begin
        v0 = a; v1 = c; v2 = b; v3 = d;
      end
      OP_SCALE: begin
        v0 = a * k; v1 = b * k; v2 = c * k; v3 = d * k;
      end
      OP_DET: v0 = det;
      OP_INVERSE: begin
        if (det == 0) o.sing = 1'b1;
        else begin
          // SV division on longint truncates toward zero
          v0 = d / det; v1 = -b / det; v2 = -c / det; v3 = a / det;
        end
      end
      OP_SOLVE: begin
        if (det == 0) o.sing = 1'b1;
        else begin
          xq = x / det; yq = y / det;
          v0 = d * xq - b * yq; v1 = a * yq - c * xq;
        end
      end
      default: ;  // unused code: all zero
    endcase
    o.r0 = v0[RES_W-1:0]; o.r1 = v1[RES_W-1:0];
    o.r2 = v2[RES_W-1:0]; o.r3 = v3[RES_W-1:0];
    return o;
  endfunction

  function automatic logic [EW-1:0] rnd_elem();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return EW'($signed($urandom_range(0, 8)) - 4);
      default: return EW'($urandom);
    endcase
  endfunction

  function automatic mat_req_t rnd_req();
    mat_req_t t;
    t.op = (($urandom_range(0, 19)) == 0) ? OP_UNUSED : OP_W'($urandom_range(0, 6));
    {t.a, t.b, t.c, t.d} = {rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem()};
    {t.p, t.q, t.r, t.s} = {rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem()};
    {t.x, t.y, t.k} = {rnd_elem(), rnd_elem(), rnd_elem()};
    // force singular or small-determinant matrices now and then
    if ((t.op == OP_INVERSE || t.op == OP_SOLVE) && $urandom_range(0, 3) == 0) begin
      t.c = t.a; t.d = t.b;
    end else if ($urandom_range(0, 4) == 0) begin
      t.a = EW'(1); t.d = EW'($urandom_range(1, 3)); t.b = '0; t.c = rnd_elem();
    end
    return t;
  endfunction

  function automatic mat_req_t mk(op_e o, int a, int b, int c, int d,
                                  int x, int y, int k);
    mat_req_t t;
    t.op = o; t.a = EW'(a); t.b = EW'(b); t.c = EW'(c); t.d = EW'(d);
    t.p = EW'(-32768); t.q = EW'(32767); t.r = EW'(-1); t.s = EW'(1);
    t.x = EW'(x); t.y = EW'(y); t.k = EW'(k);
    return t;
  endfunction

  // Handshake seen at the rising edge, used by the falling-edge driver.
  logic in_ready_o_q;

  // Sender: bursts of transfers separated by random gaps.
  int  burst_left, gap_left;
  bit  pause_drain;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cur        <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_valid_i || in_ready_o_q) begin
      // previous item (if any) was accepted at the last rising edge
      if (gap_left > 0 || req_q.size() == 0 || pause_drain) begin
        in_valid_i <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        cur        <= req_q.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ready_o_q <= 1'b0;
    end else begin
      in_ready_o_q <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) result_q.push_back(mat_compute(cur));
    end
  end

  // Receiver: stall pattern of its own, plus one long hold-off on request.
  int hold_cnt, stall_mode;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_cnt    <= 0;
      stall_mode  <= 0;
    end else if (hold_on && hold_cnt < 200) begin
      out_ready_i <= 1'b0;
      hold_cnt    <= hold_cnt + 1;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 3) != 0);
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Monitor: compare each output transfer with the oldest expectation.
  always @(posedge clk_i) begin
    mat_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result %h %h %h %h %b", $time,
                 res0_o, res1_o, res2_o, res3_o, singular_o);
        failed = 1'b1;
      end else begin
        want = result_q.pop_front();
        if (res0_o !== want.r0 || res1_o !== want.r1 || res2_o !== want.r2 ||
            res3_o !== want.r3 || singular_o !== want.sing) begin
          $display("%0t: mismatch exp %h %h %h %h %b got %h %h %h %h %b", $time,
                   want.r0, want.r1, want.r2, want.r3, want.sing,
                   res0_o, res1_o, res2_o, res3_o, singular_o);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    failed = 1'b0; hold_on = 1'b0; pause_drain = 1'b0; cycle_cnt = 0;
    rst_ni = 1'b0;
    // directed: every op, extremes, singular and truncation cases, unused code
    req_q.push_back(mk(OP_MATMUL, -32768, -32768, 32767, 32767, 0, 0, 0));
    req_q.push_back(mk(OP_MATVEC, -32768, -32768, -32768, -32768,
                       -32768, -32768, 0));
    req_q.push_back(mk(OP_TRANSPOSE, 1, -2, 3, -4, 0, 0, 0));
    req_q.push_back(mk(OP_SCALE, -32768, 32767, -1, 0, 0, 0, -32768));
    req_q.push_back(mk(OP_DET, -32768, 32767, -32768, -32768, 0, 0, 0));
    req_q.push_back(mk(OP_DET, 32767, -32768, -32768, 32767, 0, 0, 0));
    req_q.push_back(mk(OP_INVERSE, 2, 4, 1, 2, 0, 0, 0));
    req_q.push_back(mk(OP_INVERSE, 1, 0, 0, 1, 0, 0, 0));
    req_q.push_back(mk(OP_INVERSE, 3, -7, 1, 2, 0, 0, 0));
    req_q.push_back(mk(OP_INVERSE, -32768, 1, 1, 0, 0, 0, 0));
    req_q.push_back(mk(OP_SOLVE, 2, 4, 1, 2, 5, 6, 0));
    req_q.push_back(mk(OP_SOLVE, 1, 0, 0, 1, -32768, 32767, 0));
    req_q.push_back(mk(OP_SOLVE, 2, 1, 1, 1, -7, 7, 0));
    req_q.push_back(mk(OP_SOLVE, -1, 0, 0, 1, -32768, -32768, 0));
    begin
      mat_req_t t;
      t = mk(OP_MATMUL, 0, 0, 0, 0, 0, 0, 0);
      t.op = OP_UNUSED; t.a = EW'(-1); t.d = EW'(5);
      req_q.push_back(t);
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    wait (req_q.size() == 0);
    // sender pauses until every expected result is back
    pause_drain = 1'b1;
    @(negedge clk_i);
    wait (!in_valid_i);
    wait (result_q.size() == 0);
    pause_drain = 1'b0;
    for (int i = 0; i < 300; i++) req_q.push_back(rnd_req());
    // long receiver hold-off while the sender keeps offering
    hold_on = 1'b1;
    for (int i = 0; i < 300; i++) req_q.push_back(rnd_req());
    wait (req_q.size() == 0);
    @(negedge clk_i);
    wait (!in_valid_i);
    wait (result_q.size() == 0);
    repeat (LATENCY * 2) @(posedge clk_i);
    if (!failed) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
